// File: rtl/depth_histogram_min_max_defines.svh
// ----------------------------------------------------------------------------
// depth_histogram_min_max_defines.svh
// assertion helpers for the depth histogram block
// ----------------------------------------------------------------------------
`ifndef DEPTH_HISTOGRAM_MIN_MAX_DEFINES_SVH
`define DEPTH_HISTOGRAM_MIN_MAX_DEFINES_SVH

// condition holds in the same cycle
`define DHMM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the next cycle
`define DHMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/dhmm_pkg.sv
// ----------------------------------------------------------------------------
// dhmm_pkg
// types and constants of the depth histogram with frame min and max
// ----------------------------------------------------------------------------
package dhmm_pkg;

	localparam int unsigned DEPTH_BITS = 24;
	localparam int unsigned COUNT_BITS = 32;
	localparam int unsigned BIN_BITS   = 4;
	localparam int unsigned NUM_BINS   = 11;
	localparam int unsigned NUM_BANKS  = 2;

	localparam logic [BIN_BITS-1:0]   LAST_BIN   = BIN_BITS'(NUM_BINS - 1);
	localparam logic [DEPTH_BITS-1:0] FULL_SCALE = '1;
	localparam longint unsigned FULL_SCALE_L = (64'd1 << DEPTH_BITS) - 64'd1;

	typedef struct packed {
		logic [DEPTH_BITS-1:0] depth_sample;
		logic                  frame_end;
	} sample_t;

	typedef struct packed {
		logic [BIN_BITS-1:0]   bin_index;
		logic [COUNT_BITS-1:0] bin_count;
		logic [DEPTH_BITS-1:0] min_depth;
		logic [DEPTH_BITS-1:0] max_depth;
		logic                  max_valid;
		logic                  last_bin;
	} result_t;

endpackage

// File: rtl/depth_histogram_min_max.sv
// ----------------------------------------------------------------------------
// depth_histogram_min_max
// eleven-bin depth histogram with frame minimum and non-background maximum
// ----------------------------------------------------------------------------
// channel  | direction | payload   | notes
// sample   | in        | sample_t  | one depth sample, frame_end on the last one
// result   | out       | result_t  | eleven per frame, bins 0..10, last_bin on 10
//
// one sample per cycle while sample_ready is high; the bin counters live in
// a two-bank memory, one bank per frame, read-modify-write over two stages
// with one-deep write forwarding. a frame's eleven results leave one per
// cycle while result_ready is high, through a two-entry output queue.
// sample_ready drops only while the bank for the incoming frame is not yet
// fully read out, i.e. when a whole frame arrives before the report of the
// frame two back has left the counter memory.
// reset clears everything at once through per-entry valid bits; no sweep.
`include "depth_histogram_min_max_defines.svh"

module depth_histogram_min_max (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  dhmm_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_ready,
	output dhmm_pkg::result_t result
);
	import dhmm_pkg::*;

	localparam int unsigned ADDR_BITS = 1 + BIN_BITS;
	localparam int unsigned MEM_DEPTH = NUM_BANKS << BIN_BITS;

	// bin thresholds, bin >= k when depth >= ceil(k * full / 10)
	logic [NUM_BINS-2:0] ge;
	for (genvar k = 1; k < NUM_BINS; k++) begin : g_thr
		localparam longint unsigned THR =
			(FULL_SCALE_L * longint'(k) + 64'd9) / 64'd10;
		assign ge[k-1] = sample.depth_sample >= DEPTH_BITS'(THR);
	end

	logic accept;
	logic cur_bank_q;
	logic [NUM_BANKS-1:0] busy_q;
	logic [NUM_BANKS-1:0] rdy_q;

	assign sample_ready = !busy_q[cur_bank_q];
	assign accept       = sample_valid && sample_ready;

	// accumulate stage 1
	logic                  v_s1;
	logic                  last_s1;
	logic                  bank_s1;
	logic [DEPTH_BITS-1:0] depth_s1;
	logic [NUM_BINS-2:0]   ge_s1;
	logic [BIN_BITS-1:0]   bin_s1;
	logic [ADDR_BITS-1:0]  addr_s1;

	always_comb begin
		bin_s1 = '0;
		for (int i = 0; i < NUM_BINS - 1; i++) begin
			bin_s1 = bin_s1 + BIN_BITS'(ge_s1[i]);
		end
	end
	assign addr_s1 = {bank_s1, bin_s1};

	// accumulate stage 2
	logic                  v_s2;
	logic                  last_s2;
	logic [ADDR_BITS-1:0]  addr_s2;
	logic [COUNT_BITS-1:0] acc_rdata_s2;
	logic [COUNT_BITS-1:0] cnt_old_s2;
	logic [COUNT_BITS-1:0] cnt_new_s2;
	logic                  wr_v_q;
	logic [ADDR_BITS-1:0]  wr_addr_q;
	logic [COUNT_BITS-1:0] wr_data_q;
	logic [MEM_DEPTH-1:0]  cnt_vld_q;

	logic [COUNT_BITS-1:0] cnt_mem [MEM_DEPTH];

	always_comb begin
		if (wr_v_q && wr_addr_q == addr_s2) begin
			cnt_old_s2 = wr_data_q;
		end else if (cnt_vld_q[addr_s2]) begin
			cnt_old_s2 = acc_rdata_s2;
		end else begin
			cnt_old_s2 = '0;
		end
		cnt_new_s2 = (&cnt_old_s2) ? cnt_old_s2 : cnt_old_s2 + 1'b1;
	end

	// running min and max, folded in stage 1
	logic [DEPTH_BITS-1:0] run_min_q, run_max_q, run_min_nx, run_max_nx;
	logic                  run_seen_q, run_seen_nx, is_bg_s1;
	logic [DEPTH_BITS-1:0] snap_min_q [NUM_BANKS];
	logic [DEPTH_BITS-1:0] snap_max_q [NUM_BANKS];
	logic [NUM_BANKS-1:0]  snap_seen_q;

	always_comb begin
		is_bg_s1    = depth_s1 == FULL_SCALE;
		run_min_nx  = (depth_s1 < run_min_q) ? depth_s1 : run_min_q;
		run_max_nx  = (!is_bg_s1 && (!run_seen_q || depth_s1 > run_max_q)) ?
			depth_s1 : run_max_q;
		run_seen_nx = run_seen_q || !is_bg_s1;
	end

	// readout
	logic                  rd_bank_q;
	logic [BIN_BITS-1:0]   rd_k_q;
	logic [ADDR_BITS-1:0]  rd_addr;
	logic                  issue, rd_done, pop;
	logic                  rs_v_s1, rs_bank_s1, rs_vb_s1;
	logic [BIN_BITS-1:0]   rs_k_s1;
	logic [COUNT_BITS-1:0] rs_data_s1;
	result_t               rs_item;
	result_t               fifo_q [2];
	logic                  wptr_q, rptr_q;
	logic [1:0]            cnt_q;

	assign rd_addr = {rd_bank_q, rd_k_q};
	assign pop     = result_valid && result_ready;
	assign issue   = rdy_q[rd_bank_q] && ((cnt_q + 2'(rs_v_s1) <= 2'd1) || pop);
	assign rd_done = issue && rd_k_q == LAST_BIN;

	always_comb begin
		rs_item.bin_index = rs_k_s1;
		rs_item.bin_count = rs_vb_s1 ? rs_data_s1 : '0;
		rs_item.min_depth = snap_min_q[rs_bank_s1];
		rs_item.max_depth = snap_seen_q[rs_bank_s1] ? snap_max_q[rs_bank_s1] : '0;
		rs_item.max_valid = snap_seen_q[rs_bank_s1];
		rs_item.last_bin  = rs_k_s1 == LAST_BIN;
	end

	assign result_valid = cnt_q != 2'd0;
	assign result       = fifo_q[rptr_q];

	logic [NUM_BANKS-1:0] set_busy, clr_bank, set_rdy;
	always_comb begin
		set_busy = (accept && sample.frame_end) ? NUM_BANKS'(1) << cur_bank_q : '0;
		set_rdy  = (v_s2 && last_s2) ? NUM_BANKS'(1) << addr_s2[ADDR_BITS-1] : '0;
		clr_bank = rd_done ? NUM_BANKS'(1) << rd_bank_q : '0;
	end

	// memory and payload registers
	always_ff @(posedge clk) begin
		acc_rdata_s2 <= cnt_mem[addr_s1];
		rs_data_s1   <= cnt_mem[rd_addr];
		if (v_s2) begin
			cnt_mem[addr_s2] <= cnt_new_s2;
		end
		if (accept) begin
			depth_s1 <= sample.depth_sample;
			ge_s1    <= ge;
			last_s1  <= sample.frame_end;
			bank_s1  <= cur_bank_q;
		end
		addr_s2   <= addr_s1;
		last_s2   <= last_s1;
		wr_addr_q <= addr_s2;
		wr_data_q <= cnt_new_s2;
		if (v_s1 && last_s1) begin
			snap_min_q[bank_s1]  <= run_min_nx;
			snap_max_q[bank_s1]  <= run_max_nx;
			snap_seen_q[bank_s1] <= run_seen_nx;
		end
		if (issue) begin
			rs_k_s1    <= rd_k_q;
			rs_bank_s1 <= rd_bank_q;
			rs_vb_s1   <= cnt_vld_q[rd_addr];
		end
		if (rs_v_s1) begin
			fifo_q[wptr_q] <= rs_item;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_bank_q <= 1'b0;
			busy_q     <= '0;
			rdy_q      <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			wr_v_q     <= 1'b0;
			cnt_vld_q  <= '0;
			run_min_q  <= FULL_SCALE;
			run_max_q  <= '0;
			run_seen_q <= 1'b0;
			rd_bank_q  <= 1'b0;
			rd_k_q     <= '0;
			rs_v_s1    <= 1'b0;
			wptr_q     <= 1'b0;
			rptr_q     <= 1'b0;
			cnt_q      <= 2'd0;
		end else begin
			if (accept && sample.frame_end) begin
				cur_bank_q <= !cur_bank_q;
			end
			busy_q <= (busy_q | set_busy) & ~clr_bank;
			rdy_q  <= (rdy_q | set_rdy) & ~clr_bank;
			v_s1   <= accept;
			v_s2   <= v_s1;
			wr_v_q <= v_s2;
			// banks never overlap here: the one being read is not accumulating
			if (v_s2) begin
				cnt_vld_q[addr_s2] <= 1'b1;
			end
			if (issue) begin
				cnt_vld_q[rd_addr] <= 1'b0;
			end
			if (v_s1) begin
				if (last_s1) begin
					run_min_q  <= FULL_SCALE;
					run_max_q  <= '0;
					run_seen_q <= 1'b0;
				end else begin
					run_min_q  <= run_min_nx;
					run_max_q  <= run_max_nx;
					run_seen_q <= run_seen_nx;
				end
			end
			if (issue) begin
				if (rd_done) begin
					rd_k_q    <= '0;
					rd_bank_q <= !rd_bank_q;
				end else begin
					rd_k_q <= rd_k_q + 1'b1;
				end
			end
			rs_v_s1 <= issue;
			if (rs_v_s1) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(rs_v_s1) - 2'(pop);
		end
	end

	`DHMM_ASSERT_SAME(a_queue_bound, 1'b1, cnt_q != 2'd3, "output queue overflow")
	`DHMM_ASSERT_SAME(a_read_busy_bank, issue, busy_q[rd_bank_q],
		"readout of a bank with no finished frame")
	`DHMM_ASSERT_SAME(a_acc_free_bank, v_s2, !rdy_q[addr_s2[ADDR_BITS-1]],
		"count update into a bank awaiting readout")
	`DHMM_ASSERT_NEXT(a_done_frees_bank, rd_done, !busy_q[$past(rd_bank_q)],
		"bank still busy after its last read")

endmodule
